// File: rtl/core/sswp_pkg.sv
// ----------------------------------------------------------------------------
// sswp_pkg
// Shared types and constants for the segmented stack with pop-at.
// ----------------------------------------------------------------------------
package sswp_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int WORD_W   = 32;
  localparam int SIZE_W   = 7;
  localparam int DIVD_W   = SIZE_W + 1;
  localparam int START_W  = ADDR_W + SIZE_W;

  localparam logic [WORD_W-1:0] EMPTY_TOP  = 32'h8000_0000;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 7'd10;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_POP_AT = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/core/sswp_ceil_div.sv
// ----------------------------------------------------------------------------
// sswp_ceil_div
// Restoring divider, one quotient bit per cycle; yields the sub-stack count.
// ----------------------------------------------------------------------------
module sswp_ceil_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sswp_pkg::div_req_t req,
  output sswp_pkg::div_rsp_t rsp
);
  import sswp_pkg::*;

  localparam int STEP_W = $clog2(DIVD_W);

  logic [SIZE_W-1:0] rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVD_W-1:0] trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= req.dividend;
    end else if (busy_r) begin
      rem_r  <= fits ? SIZE_W'(trial - {1'b0, req.divisor}) : trial[SIZE_W-1:0];
      quo_r  <= {quo_r[DIVD_W-2:0], fits};
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(DIVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[SIZE_W-1:0];

endmodule

// File: rtl/core/segmented_stack_with_pop_at_unit.sv
// ----------------------------------------------------------------------------
// segmented_stack_with_pop_at_unit
// Stack of signed words split into sub-stacks, with push, pop and pop-at.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tuser: op; tdata: push_value, index
//  out_    | out | out_tvalid/out_tready | tdata: top, counts, empty, status
//  cfg_    | in  | cfg_tvalid/cfg_tready | tdata: segment_size
//
// Push and pop show their result after the 8-step divider that forms the
// sub-stack count is done; no new item is taken until that result is loaded.
// Pop-at finds the segment's last entry, then moves each entry above it down
// with a read and a write step: the store has one read and one write port.
// Synchronous reset empties the stack and sets segment_size to 10.
// A result word left waiting holds the next item in its final state.
// ----------------------------------------------------------------------------
module segmented_stack_with_pop_at_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // push_value[31:0], segment_index[37:32]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // top_value[31:0], entry_count[38:32],
                                  // segment_count[45:39], is_empty[46],
                                  // status[48:47]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // segment_size[6:0]
);
  import sswp_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_SH_RD  = 4'd3;
  localparam logic [3:0] S_SH_WR  = 4'd4;
  localparam logic [3:0] S_DIV_GO = 4'd5;
  localparam logic [3:0] S_DIV_WT = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;

  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [SIZE_W-1:0]  size_r;
  logic [1:0]         op_r;
  logic [WORD_W-1:0]  val_r;
  logic [ADDR_W-1:0]  k_r;
  logic [1:0]         status_r, status_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic               out_valid_r;
  logic [55:0]        out_data_r;

  logic [WORD_W-1:0]  mem [CAPACITY];
  logic [WORD_W-1:0]  rdata_r;
  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [WORD_W-1:0]  wdata;

  logic [SIZE_W-1:0]  size_eff;
  logic [START_W:0]   end_full;
  logic [CNT_W-1:0]   end_cl;
  logic [ADDR_W-1:0]  pos;
  logic               out_free;
  logic               load_out;
  div_req_t           dreq;
  div_rsp_t           drsp;

  assign size_eff   = (size_r == '0) ? SIZE_W'(1) : size_r;
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign load_out   = (state_r == S_FIN) && out_free;

  assign end_full = {1'b0, start_r} + (START_W+1)'(size_eff);
  assign end_cl   = (end_full > (START_W+1)'(fill_r)) ? fill_r : end_full[CNT_W-1:0];
  assign pos      = ADDR_W'(end_cl - 1'b1);

  assign dreq.start    = (state_r == S_DIV_GO);
  assign dreq.dividend = DIVD_W'(fill_r) + DIVD_W'(size_eff) - 1'b1;
  assign dreq.divisor  = size_eff;

  sswp_ceil_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    status_nxt = status_r;
    start_nxt  = start_r;
    idx_nxt    = idx_r;
    we         = 1'b0;
    waddr      = fill_r[ADDR_W-1:0];
    wdata      = val_r;
    re         = 1'b0;
    raddr      = ADDR_W'(fill_r - 1'b1);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt  = S_EXEC;
          status_nxt = ST_DONE;
        end
      end
      S_EXEC: begin
        state_nxt = S_DIV_GO;
        case (op_r)
          OP_PUSH: begin
            if (fill_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              we       = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end
          OP_POP: begin
            if (fill_r == '0) begin
              status_nxt = ST_IGNORED;
            end else begin
              fill_nxt = fill_r - 1'b1;
            end
          end
          OP_POP_AT: begin
            start_nxt = START_W'(k_r) * START_W'(size_eff);
            state_nxt = S_POS;
          end
          default: begin
          end
        endcase
      end
      S_POS: begin
        if (start_r >= START_W'(fill_r)) begin
          status_nxt = ST_IGNORED;
          state_nxt  = S_DIV_GO;
        end else if (CNT_W'(pos) + 1'b1 < fill_r) begin
          idx_nxt   = pos;
          state_nxt = S_SH_RD;
        end else begin
          fill_nxt  = fill_r - 1'b1;
          state_nxt = S_DIV_GO;
        end
      end
      S_SH_RD: begin
        re        = 1'b1;
        raddr     = idx_r + 1'b1;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = idx_r;
        wdata = rdata_r;
        if (CNT_W'(idx_r) + CNT_W'(2) < fill_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SH_RD;
        end else begin
          fill_nxt  = fill_r - 1'b1;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        re        = 1'b1;
        state_nxt = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (drsp.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      size_r      <= RESET_SIZE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (cfg_tvalid && cfg_tready) begin
        size_r <= cfg_tdata[SIZE_W-1:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    start_r  <= start_nxt;
    idx_r    <= idx_nxt;
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      val_r <= in_tdata[WORD_W-1:0];
      k_r   <= in_tdata[WORD_W+ADDR_W-1:WORD_W];
    end
    if (load_out) begin
      out_data_r <= {7'd0, status_r, (fill_r == '0), drsp.quotient, fill_r,
                     (fill_r == '0) ? EMPTY_TOP : rdata_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[48:47] == ST_FULL) |-> out_tdata[38:32] == CNT_W'(CAPACITY))
    else $error("push rejected while not full");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[46]) |-> (out_tdata[31:0] == EMPTY_TOP && out_tdata[45:39] == '0))
    else $error("empty result with stale top or count");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_WR) |-> (CNT_W'(idx_r) + 1'b1 < fill_r))
    else $error("shift beyond fill");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while busy");

endmodule
